// File: rtl/mse_pkg.sv
// Package for the math-style UTF-8 encoder: style codes, code point bases,
// letterlike fill tables and the queue entry type. No dependencies.
`default_nettype none

package mse_pkg;

  localparam int CP_W = 21;

  localparam logic [3:0] MODE_NORMAL       = 4'd0;
  localparam logic [3:0] MODE_BOLD         = 4'd1;
  localparam logic [3:0] MODE_ITALIC       = 4'd2;
  localparam logic [3:0] MODE_BOLD_ITALIC  = 4'd3;
  localparam logic [3:0] MODE_SCRIPT       = 4'd4;
  localparam logic [3:0] MODE_BOLD_SCRIPT  = 4'd5;
  localparam logic [3:0] MODE_DOUBLE       = 4'd6;
  localparam logic [3:0] MODE_FRAKTUR      = 4'd7;
  localparam logic [3:0] MODE_BOLD_FRAKTUR = 4'd8;

  localparam logic [CP_W-1:0] BOLD_UPPER      = 21'h1D400;
  localparam logic [CP_W-1:0] BOLD_LOWER      = 21'h1D41A;
  localparam logic [CP_W-1:0] BOLD_DIGIT      = 21'h1D7CE;
  localparam logic [CP_W-1:0] ITALIC_UPPER    = 21'h1D434;
  localparam logic [CP_W-1:0] ITALIC_LOWER    = 21'h1D44E;
  localparam logic [CP_W-1:0] ITALIC_SMALL_H  = 21'h0210E;
  localparam logic [CP_W-1:0] BITALIC_UPPER   = 21'h1D468;
  localparam logic [CP_W-1:0] BITALIC_LOWER   = 21'h1D482;
  localparam logic [CP_W-1:0] BSCRIPT_UPPER   = 21'h1D4D0;
  localparam logic [CP_W-1:0] BSCRIPT_LOWER   = 21'h1D4EA;
  localparam logic [CP_W-1:0] DOUBLE_LOWER    = 21'h1D552;
  localparam logic [CP_W-1:0] DOUBLE_DIGIT    = 21'h1D7D8;
  localparam logic [CP_W-1:0] FRAKTUR_LOWER   = 21'h1D51E;
  localparam logic [CP_W-1:0] BFRAKTUR_UPPER  = 21'h1D56C;
  localparam logic [CP_W-1:0] BFRAKTUR_LOWER  = 21'h1D586;

  // Fill tables, entry 0 is letter A.
  localparam logic [0:25][CP_W-1:0] SCRIPT_UPPER = {
    21'h1D49C, 21'h0212C, 21'h1D49E, 21'h1D49F, 21'h02130, 21'h02131, 21'h1D4A2,
    21'h0210B, 21'h02110, 21'h1D4A5, 21'h1D4A6, 21'h02112, 21'h02133, 21'h1D4A9,
    21'h1D4AA, 21'h1D4AB, 21'h1D4AC, 21'h0211B, 21'h1D4AE, 21'h1D4AF, 21'h1D4B0,
    21'h1D4B1, 21'h1D4B2, 21'h1D4B3, 21'h1D4B4, 21'h1D4B5
  };
  localparam logic [0:25][CP_W-1:0] SCRIPT_LOWER = {
    21'h1D4B6, 21'h1D4B7, 21'h1D4B8, 21'h1D4B9, 21'h0212F, 21'h1D4BB, 21'h0210A,
    21'h1D4BD, 21'h1D4BE, 21'h1D4BF, 21'h1D4C0, 21'h1D4C1, 21'h1D4C2, 21'h1D4C3,
    21'h02134, 21'h1D4C5, 21'h1D4C6, 21'h1D4C7, 21'h1D4C8, 21'h1D4C9, 21'h1D4CA,
    21'h1D4CB, 21'h1D4CC, 21'h1D4CD, 21'h1D4CE, 21'h1D4CF
  };
  localparam logic [0:25][CP_W-1:0] DOUBLE_UPPER = {
    21'h1D538, 21'h1D539, 21'h02102, 21'h1D53B, 21'h1D53C, 21'h1D53D, 21'h1D53E,
    21'h0210D, 21'h1D540, 21'h1D541, 21'h1D542, 21'h1D543, 21'h1D544, 21'h02115,
    21'h1D546, 21'h02119, 21'h0211A, 21'h0211D, 21'h1D54A, 21'h1D54B, 21'h1D54C,
    21'h1D54D, 21'h1D54E, 21'h1D54F, 21'h1D550, 21'h02124
  };
  localparam logic [0:25][CP_W-1:0] FRAKTUR_UPPER = {
    21'h1D504, 21'h1D505, 21'h0212D, 21'h1D507, 21'h1D508, 21'h1D509, 21'h1D50A,
    21'h0210C, 21'h02111, 21'h1D50D, 21'h1D50E, 21'h1D50F, 21'h1D510, 21'h1D511,
    21'h1D512, 21'h1D513, 21'h1D514, 21'h0211C, 21'h1D516, 21'h1D517, 21'h1D518,
    21'h1D519, 21'h1D51A, 21'h1D51B, 21'h1D51C, 21'h02128
  };

  // One encoded character: up to four bytes, first byte in slot 0.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } enc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/ascii_math_style_utf8_encoder_top.sv
// With the queue empty, an accepted byte is registered in the front stage, pushed into
// the queue and registered by the back end onto the result ports. Each character has 1
// to 4 UTF-8 bytes, sent in turn through the single-byte result port of the back-end
// serializer; the queue absorbs the difference, letting the front stage accept meanwhile.
// Reset: synchronous, clears queue, front and back control and sets the style to normal.
// Results cannot be stalled; busy rises only while the queue and front stage are full.
`default_nettype none

module ascii_math_style_utf8_encoder_top import mse_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_byte,
  input  wire logic       style_we,
  input  wire logic [3:0] style_wdata,
  output logic            strobe,
  output logic [7:0]      out_byte,
  output logic            last_byte
);

  logic [3:0] style_mode;
  logic       push;
  logic       pop;
  enc_t       push_data;
  enc_t       head;
  q_stat_t    q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      style_mode <= MODE_NORMAL;
    end else if (style_we) begin
      style_mode <= style_wdata;
    end
  end

  mse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .in_byte    (in_byte),
    .style_mode (style_mode),
    .q_stat     (q_stat),
    .busy       (busy),
    .push       (push),
    .push_data  (push_data)
  );

  mse_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  mse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .strobe    (strobe),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule

`default_nettype wire

// File: rtl/mse_front.sv
// Front end: accepts input bytes, maps them to styled code points and
// encodes them into UTF-8 queue entries. Depends on mse_pkg.
`default_nettype none

module mse_front import mse_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [7:0] in_byte,
  input  wire logic [3:0] style_mode,
  input  wire q_stat_t    q_stat,
  output logic            busy,
  output logic            push,
  output enc_t            push_data
);

  function automatic logic [CP_W-1:0] style_cp(input logic [7:0] c, input logic [3:0] m);
    logic           up;
    logic           lo;
    logic           dg;
    logic [4:0]     ai;
    logic [CP_W-1:0] di;
    logic [CP_W-1:0] aiw;
    logic [CP_W-1:0] cp;
    up  = (c >= 8'h41) && (c <= 8'h5A);
    lo  = (c >= 8'h61) && (c <= 8'h7A);
    dg  = (c >= 8'h30) && (c <= 8'h39);
    ai  = up ? 5'(c - 8'h41) : (lo ? 5'(c - 8'h61) : 5'd0);
    aiw = CP_W'(ai);
    di  = dg ? CP_W'(c[3:0]) : '0;
    cp  = CP_W'(c);
    case (m)
      MODE_BOLD: begin
        if (up) cp = BOLD_UPPER + aiw;
        else if (lo) cp = BOLD_LOWER + aiw;
        else if (dg) cp = BOLD_DIGIT + di;
      end
      MODE_ITALIC: begin
        if (up) cp = ITALIC_UPPER + aiw;
        else if (lo) cp = (c == 8'h68) ? ITALIC_SMALL_H : ITALIC_LOWER + aiw;
      end
      MODE_BOLD_ITALIC: begin
        if (up) cp = BITALIC_UPPER + aiw;
        else if (lo) cp = BITALIC_LOWER + aiw;
      end
      MODE_SCRIPT: begin
        if (up) cp = SCRIPT_UPPER[ai];
        else if (lo) cp = SCRIPT_LOWER[ai];
      end
      MODE_BOLD_SCRIPT: begin
        if (up) cp = BSCRIPT_UPPER + aiw;
        else if (lo) cp = BSCRIPT_LOWER + aiw;
      end
      MODE_DOUBLE: begin
        if (up) cp = DOUBLE_UPPER[ai];
        else if (lo) cp = DOUBLE_LOWER + aiw;
        else if (dg) cp = DOUBLE_DIGIT + di;
      end
      MODE_FRAKTUR: begin
        if (up) cp = FRAKTUR_UPPER[ai];
        else if (lo) cp = FRAKTUR_LOWER + aiw;
      end
      MODE_BOLD_FRAKTUR: begin
        if (up) cp = BFRAKTUR_UPPER + aiw;
        else if (lo) cp = BFRAKTUR_LOWER + aiw;
      end
      default: cp = CP_W'(c);
    endcase
    return cp;
  endfunction

  logic            front_valid;
  logic            front_valid_next;
  logic [CP_W-1:0] cp;
  logic            raw;
  logic            accept;
  logic            advance;

  assign advance = front_valid && !q_stat.full;
  assign busy    = front_valid && q_stat.full;
  assign accept  = start && !busy;
  assign push    = advance;

  always_comb begin
    front_valid_next = front_valid;
    if (accept) front_valid_next = 1'b1;
    else if (advance) front_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  // Normal mode, unused codes and non-ASCII bytes pass through as one byte.
  always_ff @(posedge clk) begin
    if (accept) begin
      raw <= (style_mode == MODE_NORMAL) || (style_mode > MODE_BOLD_FRAKTUR) || in_byte[7];
      cp  <= style_cp(in_byte, style_mode);
    end
  end

  always_comb begin
    push_data.bytes    = '0;
    push_data.last_idx = 2'd0;
    if (raw || cp <= 21'h7F) begin
      push_data.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      push_data.bytes[0] = {3'b110, cp[10:6]};
      push_data.bytes[1] = {2'b10, cp[5:0]};
      push_data.last_idx = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      push_data.bytes[0] = {4'b1110, cp[15:12]};
      push_data.bytes[1] = {2'b10, cp[11:6]};
      push_data.bytes[2] = {2'b10, cp[5:0]};
      push_data.last_idx = 2'd2;
    end else begin
      push_data.bytes[0] = {5'b11110, cp[20:18]};
      push_data.bytes[1] = {2'b10, cp[17:12]};
      push_data.bytes[2] = {2'b10, cp[11:6]};
      push_data.bytes[3] = {2'b10, cp[5:0]};
      push_data.last_idx = 2'd3;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mse_fifo.sv
// Short queue of encoded characters between front and back end.
// Depends on mse_pkg for the entry and status types.
`default_nettype none

module mse_fifo import mse_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire enc_t push_data,
  input  wire logic pop,
  output enc_t      head,
  output q_stat_t   stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  enc_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// File: rtl/mse_back.sv
// Back end: serializes the queue head one UTF-8 byte per cycle onto the
// registered result ports. Depends on mse_pkg.
`default_nettype none

module mse_back import mse_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire enc_t    head,
  input  wire q_stat_t q_stat,
  output logic         pop,
  output logic         strobe,
  output logic [7:0]   out_byte,
  output logic         last_byte
);

  logic [1:0] idx;
  logic       emit;
  logic       is_last;

  assign emit    = !q_stat.empty;
  assign is_last = (idx == head.last_idx);
  assign pop     = emit && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= 2'd0;
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
      // advance through the entry, rewind once its last byte goes out
      if (emit) idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    out_byte  <= head.bytes[idx];
    last_byte <= is_last;
  end

endmodule

`default_nettype wire

// File: rtl/mse_checker.sv
// Port-level checks for the encoder top level, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module mse_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic [7:0] out_byte,
  input wire logic       last_byte
);

  // reset empties the block: no result and no backpressure right after
  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !strobe))
    else $error("busy or strobe after reset");

  // a multi-byte character goes out without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_byte) |=> strobe)
    else $error("gap inside a multi-byte transaction");

  // every byte before the last one is part of a multi-byte sequence
  a_lead_high: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_byte) |-> out_byte[7])
    else $error("non-final byte is plain ASCII");

  // bytes that follow a non-final byte are continuation bytes
  a_continuation: assert property (@(posedge clk) disable iff (rst)
    (strobe && $past(strobe) && !$past(last_byte) && !$past(rst)) |->
      (out_byte[7:6] == 2'b10))
    else $error("missing continuation byte");

endmodule

bind ascii_math_style_utf8_encoder_top mse_checker u_mse_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .strobe    (strobe),
  .out_byte  (out_byte),
  .last_byte (last_byte)
);

`default_nettype wire
